@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge while reset is released.
`define SC2C_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds while reset is released.
`define SC2C_NEVER(lbl, clk, rst_n, cond, msg) \
	`SC2C_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

@@ hdl/sc2c_pkg.sv @@
`default_nettype none

package sc2c_pkg;

	typedef enum logic [1:0] {
		KIND_CHAR  = 2'd0,
		KIND_COMBO = 2'd1,
		KIND_RESET = 2'd2,
		KIND_LED   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
		logic [5:0] mods_next;
	} dec_t;

	localparam int ModShift  = 0;
	localparam int ModCtrl   = 1;
	localparam int ModAlt    = 2;
	localparam int ModScroll = 3;
	localparam int ModNum    = 4;
	localparam int ModCaps   = 5;

	localparam logic [6:0] KeyAlt    = 7'h38;
	localparam logic [6:0] KeyCtrl   = 7'h1D;
	localparam logic [6:0] KeyLShift = 7'h2A;
	localparam logic [6:0] KeyRShift = 7'h36;
	localparam logic [6:0] KeyScroll = 7'h46;
	localparam logic [6:0] KeyNum    = 7'h45;
	localparam logic [6:0] KeyCaps   = 7'h3A;

	localparam logic [7:0] LedCmd    = 8'hED;
	localparam logic [7:0] CodeDel   = 8'h91;
	localparam logic [7:0] ChLowA    = 8'h61;
	localparam logic [7:0] ChLowZ    = 8'h7A;
	localparam logic [7:0] ChUpA     = 8'h41;
	localparam logic [7:0] ChUpZ     = 8'h5A;
	localparam logic [7:0] ChBracket = 8'h5B;
	localparam logic [7:0] ChUnder   = 8'h5F;
	localparam logic [7:0] CtrlOfs   = 8'h40;

	localparam int unsigned TabLen = 89;

	localparam logic [7:0] PLAIN_TAB [0:TabLen-1] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,
		8'h00, 8'h20, 8'h00, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84,
		8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h00, 8'h00, 8'h92,
		8'h97, 8'h94, 8'h2D, 8'h96, 8'h35, 8'h99, 8'h2B, 8'h93,
		8'h98, 8'h95, 8'h90, 8'h91, 8'h00, 8'h00, 8'h00, 8'h8A,
		8'h8B
	};

	localparam logic [7:0] SHIFT_TAB [0:TabLen-1] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
		8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00,
		8'h00, 8'h20, 8'h00, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84,
		8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h00, 8'h00, 8'h92,
		8'h97, 8'h94, 8'h2D, 8'h96, 8'h35, 8'h99, 8'h2B, 8'h93,
		8'h98, 8'h95, 8'h90, 8'h91, 8'h00, 8'h00, 8'h00, 8'h8A,
		8'h8B
	};

endpackage

`default_nettype wire

@@ hdl/sc2c_decode.sv @@
`default_nettype none

module sc2c_decode (
	input  wire logic [7:0]     code,
	input  wire logic [5:0]     mods,
	output sc2c_pkg::dec_t      dec
);

	logic [6:0] key;
	logic       brk;
	logic [5:0] mod_hit;
	logic       in_tab;
	logic [7:0] p;
	logic [7:0] s;
	logic [5:0] m;

	assign key    = code[6:0];
	assign brk    = code[7];
	assign in_tab = ({25'd0, key} < sc2c_pkg::TabLen);
	assign p      = in_tab ? sc2c_pkg::PLAIN_TAB[key] : 8'h00;
	assign s      = in_tab ? sc2c_pkg::SHIFT_TAB[key] : 8'h00;

	always_comb begin
		mod_hit = 6'd0;
		if (key == sc2c_pkg::KeyAlt) begin
			mod_hit[sc2c_pkg::ModAlt] = 1'b1;
		end
		if (key == sc2c_pkg::KeyCtrl) begin
			mod_hit[sc2c_pkg::ModCtrl] = 1'b1;
		end
		if (key == sc2c_pkg::KeyLShift || key == sc2c_pkg::KeyRShift) begin
			mod_hit[sc2c_pkg::ModShift] = 1'b1;
		end
	end

	always_comb begin
		m             = mods;
		dec.count     = 2'd0;
		dec.r0.kind   = sc2c_pkg::KIND_CHAR;
		dec.r0.value  = 8'h00;
		dec.r0.last   = 1'b1;
		dec.r1.kind   = sc2c_pkg::KIND_LED;
		dec.r1.value  = 8'h00;
		dec.r1.last   = 1'b1;
		if (brk) begin
			m = mods & ~mod_hit;
		end else if (mod_hit != 6'd0) begin
			m = mods | mod_hit;
		end else if (key == sc2c_pkg::KeyScroll || key == sc2c_pkg::KeyNum ||
				key == sc2c_pkg::KeyCaps) begin
			if (key == sc2c_pkg::KeyScroll) begin
				m[sc2c_pkg::ModScroll] = ~mods[sc2c_pkg::ModScroll];
			end else if (key == sc2c_pkg::KeyNum) begin
				m[sc2c_pkg::ModNum] = ~mods[sc2c_pkg::ModNum];
			end else begin
				m[sc2c_pkg::ModCaps] = ~mods[sc2c_pkg::ModCaps];
			end
			dec.count    = 2'd2;
			dec.r0.kind  = sc2c_pkg::KIND_LED;
			dec.r0.value = sc2c_pkg::LedCmd;
			dec.r0.last  = 1'b0;
			dec.r1.value = {5'd0, m[sc2c_pkg::ModCaps], m[sc2c_pkg::ModNum],
				m[sc2c_pkg::ModScroll]};
		end else if (!in_tab) begin
			dec.count = 2'd0;
		end else if (mods[sc2c_pkg::ModAlt] && mods[sc2c_pkg::ModCtrl]) begin
			dec.count = 2'd1;
			if (s == sc2c_pkg::CodeDel) begin
				dec.r0.kind = sc2c_pkg::KIND_RESET;
			end else begin
				dec.r0.kind  = sc2c_pkg::KIND_COMBO;
				dec.r0.value = s;
			end
		end else if (mods[sc2c_pkg::ModCtrl]) begin
			if (p >= sc2c_pkg::ChLowA && p <= sc2c_pkg::ChLowZ) begin
				dec.count    = 2'd1;
				dec.r0.value = p - sc2c_pkg::ChLowA;
			end else if (p >= sc2c_pkg::ChBracket && p <= sc2c_pkg::ChUnder) begin
				dec.count    = 2'd1;
				dec.r0.value = p - sc2c_pkg::CtrlOfs;
			end
		end else if (mods[sc2c_pkg::ModShift]) begin
			if (s != 8'h00) begin
				dec.count = 2'd1;
				if (mods[sc2c_pkg::ModCaps] && s >= sc2c_pkg::ChUpA &&
						s <= sc2c_pkg::ChUpZ) begin
					dec.r0.value = p;
				end else begin
					dec.r0.value = s;
				end
			end
		end else begin
			if (p != 8'h00) begin
				dec.count = 2'd1;
				if (mods[sc2c_pkg::ModCaps] && p >= sc2c_pkg::ChLowA &&
						p <= sc2c_pkg::ChLowZ) begin
					dec.r0.value = s;
				end else begin
					dec.r0.value = p;
				end
			end
		end
		dec.mods_next = m;
	end

endmodule

`default_nettype wire

@@ hdl/sc2c_outbuf.sv @@
`default_nettype none

module sc2c_outbuf (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  sc2c_pkg::dec_t       dec,
	output logic                 free,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output sc2c_pkg::result_t    out_res
);

	logic                 out_valid_q;
	logic                 pend_valid_q;
	sc2c_pkg::result_t    out_q;
	sc2c_pkg::result_t    pend_q;
	logic                 pop;
	logic                 take;

	assign pop       = out_valid_q && out_ready;
	assign free      = !out_valid_q || (out_ready && !pend_valid_q);
	assign take      = load && (dec.count != 2'd0);
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q  <= 1'b1;
			pend_valid_q <= (dec.count == 2'd2);
		end else if (pop) begin
			out_valid_q  <= pend_valid_q;
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q  <= dec.r0;
			pend_q <= dec.r1;
		end else if (pop) begin
			out_q <= pend_q;
		end
	end

endmodule

`default_nettype wire

@@ hdl/scancode_set1_to_char_translator.sv @@
// An accepted scancode beat is registered in code_s1, then its results in the output buffer.
// Throughput: one scancode beat per cycle while out_ready is high; a lock key holds the input
// until its second result is taken, as its two results leave the output register one per cycle.
// Reset: arst_n clears the modifier bits and empties the input and output stages.
`default_nettype none

module scancode_set1_to_char_translator (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] key_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      kind,
	output logic [7:0]      value,
	output logic            last
);

	logic                 valid_s1;
	logic [7:0]           code_s1;
	logic [5:0]           mod_q;
	logic                 advance;
	logic                 buf_free;
	sc2c_pkg::dec_t       dec;
	sc2c_pkg::result_t    res;

	sc2c_decode u_decode (
		.code (code_s1),
		.mods (mod_q),
		.dec  (dec)
	);

	sc2c_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.dec       (dec),
		.free      (buf_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (res)
	);

	assign advance  = valid_s1 && ((dec.count == 2'd0) || buf_free);
	assign in_ready = !valid_s1 || advance;
	assign kind     = res.kind;
	assign value    = res.value;
	assign last     = res.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mod_q    <= 6'd0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				mod_q <= dec.mods_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			code_s1 <= key_byte;
		end
	end

endmodule

`default_nettype wire

@@ hdl/sc2c_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module sc2c_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] kind,
	input wire logic [7:0] value,
	input wire logic       last
);

	// A stalled result beat must hold.
	`SC2C_ASSERT(a_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable({kind, value, last}), "stalled result changed")
	// The first beat of a lock sequence is the LED command.
	`SC2C_ASSERT(a_led_cmd, clk, arst_n, out_valid && kind == sc2c_pkg::KIND_LED && !last |-> value == sc2c_pkg::LedCmd, "LED command byte wrong")
	// The LED state beat follows the command at once.
	`SC2C_ASSERT(a_led_pair, clk, arst_n, out_valid && out_ready && kind == sc2c_pkg::KIND_LED && !last |=> out_valid && kind == sc2c_pkg::KIND_LED && last && value[7:3] == 5'd0, "LED state beat missing")
	// Only the LED command is not the final result of its scancode.
	`SC2C_NEVER(a_single, clk, arst_n, out_valid && !last && kind != sc2c_pkg::KIND_LED, "non-final beat outside a lock sequence")
	// A soft reset carries a zero value.
	`SC2C_ASSERT(a_reset_val, clk, arst_n, out_valid && kind == sc2c_pkg::KIND_RESET |-> value == 8'h00, "soft reset value not zero")

endmodule

bind scancode_set1_to_char_translator sc2c_checker u_sc2c_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.kind      (kind),
	.value     (value),
	.last      (last)
);

`default_nettype wire

@@ dv/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		sc2c_pkg::kind_t kind;
		logic [7:0]      value;
		logic            last;
	} key_result_t;

	typedef struct packed {
		logic [7:0]      code;
		logic            typed;
		logic [1:0]      n;
		sc2c_pkg::kind_t k0;
		logic [7:0]      v0;
		sc2c_pkg::kind_t k1;
		logic [7:0]      v1;
	} key_row_t;

	localparam logic       TYPED     = 1'b1;
	localparam logic       PREDICTED = 1'b0;
	localparam int         KEY_COUNT = 89;
	localparam int         LONG_HOLD = 300;
	localparam int         HOLD_AT   = 100;
	localparam int         RAND_ITEMS = 400;
	localparam logic [7:0] LED_CMD   = 8'hED;
	localparam logic [7:0] DEL_CODE  = 8'h91;
	localparam logic [7:0] LOW_A     = 8'h61;
	localparam logic [7:0] LOW_Z     = 8'h7A;
	localparam logic [7:0] UP_A      = 8'h41;
	localparam logic [7:0] UP_Z      = 8'h5A;
	localparam logic [7:0] OPEN_BR   = 8'h5B;
	localparam logic [7:0] UNDERLINE = 8'h5F;
	localparam logic [7:0] ESC_CODE  = 8'h1B;

	localparam logic [7:0] PLAIN_KEYS [0:KEY_COUNT-1] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,
		8'h00, 8'h20, 8'h00, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84,
		8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h00, 8'h00, 8'h92,
		8'h97, 8'h94, 8'h2D, 8'h96, 8'h35, 8'h99, 8'h2B, 8'h93,
		8'h98, 8'h95, 8'h90, 8'h91, 8'h00, 8'h00, 8'h00, 8'h8A,
		8'h8B
	};

	localparam logic [7:0] SHIFTED_KEYS [0:KEY_COUNT-1] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
		8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00,
		8'h00, 8'h20, 8'h00, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84,
		8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h00, 8'h00, 8'h92,
		8'h97, 8'h94, 8'h2D, 8'h96, 8'h35, 8'h99, 8'h2B, 8'h93,
		8'h98, 8'h95, 8'h90, 8'h91, 8'h00, 8'h00, 8'h00, 8'h8A,
		8'h8B
	};

	localparam int ROW_COUNT = 27;
	localparam key_row_t KEY_ROWS [0:ROW_COUNT-1] = '{
		'{8'h00, TYPED,     2'd0, sc2c_pkg::KIND_CHAR,  8'h00, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'h1E, TYPED,     2'd1, sc2c_pkg::KIND_CHAR,  8'h61, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'h3A, TYPED,     2'd2, sc2c_pkg::KIND_LED,   8'hED, sc2c_pkg::KIND_LED,  8'h04},
		'{8'h1E, PREDICTED, 2'd0, sc2c_pkg::KIND_CHAR,  8'h00, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'h2A, TYPED,     2'd0, sc2c_pkg::KIND_CHAR,  8'h00, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'h1E, PREDICTED, 2'd0, sc2c_pkg::KIND_CHAR,  8'h00, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'h02, PREDICTED, 2'd0, sc2c_pkg::KIND_CHAR,  8'h00, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'hAA, TYPED,     2'd0, sc2c_pkg::KIND_CHAR,  8'h00, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'h45, TYPED,     2'd2, sc2c_pkg::KIND_LED,   8'hED, sc2c_pkg::KIND_LED,  8'h06},
		'{8'h46, TYPED,     2'd2, sc2c_pkg::KIND_LED,   8'hED, sc2c_pkg::KIND_LED,  8'h07},
		'{8'h1D, TYPED,     2'd0, sc2c_pkg::KIND_CHAR,  8'h00, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'h1E, PREDICTED, 2'd0, sc2c_pkg::KIND_CHAR,  8'h00, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'h1A, PREDICTED, 2'd0, sc2c_pkg::KIND_CHAR,  8'h00, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'h02, PREDICTED, 2'd0, sc2c_pkg::KIND_CHAR,  8'h00, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'h38, TYPED,     2'd0, sc2c_pkg::KIND_CHAR,  8'h00, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'h53, TYPED,     2'd1, sc2c_pkg::KIND_RESET, 8'h00, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'h10, PREDICTED, 2'd0, sc2c_pkg::KIND_CHAR,  8'h00, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'h00, PREDICTED, 2'd0, sc2c_pkg::KIND_CHAR,  8'h00, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'h7F, TYPED,     2'd0, sc2c_pkg::KIND_CHAR,  8'h00, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'hE0, TYPED,     2'd0, sc2c_pkg::KIND_CHAR,  8'h00, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'hB8, TYPED,     2'd0, sc2c_pkg::KIND_CHAR,  8'h00, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'h9D, TYPED,     2'd0, sc2c_pkg::KIND_CHAR,  8'h00, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'h58, PREDICTED, 2'd0, sc2c_pkg::KIND_CHAR,  8'h00, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'hFF, TYPED,     2'd0, sc2c_pkg::KIND_CHAR,  8'h00, sc2c_pkg::KIND_CHAR, 8'h00},
		'{8'h3A, TYPED,     2'd2, sc2c_pkg::KIND_LED,   8'hED, sc2c_pkg::KIND_LED,  8'h03},
		'{8'h45, TYPED,     2'd2, sc2c_pkg::KIND_LED,   8'hED, sc2c_pkg::KIND_LED,  8'h01},
		'{8'h46, TYPED,     2'd2, sc2c_pkg::KIND_LED,   8'hED, sc2c_pkg::KIND_LED,  8'h00}
	};

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] key_byte  = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] value;
	logic       last;

	logic [5:0]  held_mods = 6'd0;
	int unsigned decoded_n;
	key_result_t decoded [0:1];
	key_result_t char_queue [$];
	int unsigned mismatches = 0;
	bit          long_hold_due = 1'b0;

	scancode_set1_to_char_translator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.key_byte  (key_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.value     (value),
		.last      (last)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("[%0t] %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void add_result(input sc2c_pkg::kind_t k, input logic [7:0] v);
		decoded[decoded_n].kind  = k;
		decoded[decoded_n].value = v;
		decoded_n++;
	endfunction

	// Updates the modifier bits for one scancode and works out the results it yields.
	function automatic void decode_key(input logic [7:0] code);
		logic [6:0] key;
		logic [5:0] mask;
		logic [7:0] t;
		key = code[6:0];
		decoded_n = 0;
		mask = 6'd0;
		if (key == sc2c_pkg::KeyAlt)
			mask[sc2c_pkg::ModAlt] = 1'b1;
		else if (key == sc2c_pkg::KeyCtrl)
			mask[sc2c_pkg::ModCtrl] = 1'b1;
		else if (key == sc2c_pkg::KeyLShift || key == sc2c_pkg::KeyRShift)
			mask[sc2c_pkg::ModShift] = 1'b1;
		if (code[7]) begin
			held_mods &= ~mask;
			return;
		end
		if (mask != 6'd0) begin
			held_mods |= mask;
			return;
		end
		if (key == sc2c_pkg::KeyScroll || key == sc2c_pkg::KeyNum ||
				key == sc2c_pkg::KeyCaps) begin
			if (key == sc2c_pkg::KeyScroll)
				held_mods[sc2c_pkg::ModScroll] = ~held_mods[sc2c_pkg::ModScroll];
			else if (key == sc2c_pkg::KeyNum)
				held_mods[sc2c_pkg::ModNum] = ~held_mods[sc2c_pkg::ModNum];
			else
				held_mods[sc2c_pkg::ModCaps] = ~held_mods[sc2c_pkg::ModCaps];
			add_result(sc2c_pkg::KIND_LED, LED_CMD);
			add_result(sc2c_pkg::KIND_LED, {5'd0, held_mods[sc2c_pkg::ModCaps],
				held_mods[sc2c_pkg::ModNum], held_mods[sc2c_pkg::ModScroll]});
			return;
		end
		if (key >= KEY_COUNT)
			return;
		if (held_mods[sc2c_pkg::ModCtrl] && held_mods[sc2c_pkg::ModAlt]) begin
			t = SHIFTED_KEYS[key];
			if (t == DEL_CODE)
				add_result(sc2c_pkg::KIND_RESET, 8'h00);
			else
				add_result(sc2c_pkg::KIND_COMBO, t);
			return;
		end
		if (held_mods[sc2c_pkg::ModCtrl]) begin
			t = PLAIN_KEYS[key];
			if (t >= LOW_A && t <= LOW_Z)
				add_result(sc2c_pkg::KIND_CHAR, t - LOW_A);
			else if (t >= OPEN_BR && t <= UNDERLINE)
				add_result(sc2c_pkg::KIND_CHAR, t - OPEN_BR + ESC_CODE);
			return;
		end
		if (held_mods[sc2c_pkg::ModShift]) begin
			t = SHIFTED_KEYS[key];
			if (held_mods[sc2c_pkg::ModCaps] && t >= UP_A && t <= UP_Z)
				t = PLAIN_KEYS[key];
		end else begin
			t = PLAIN_KEYS[key];
			if (held_mods[sc2c_pkg::ModCaps] && t >= LOW_A && t <= LOW_Z)
				t = SHIFTED_KEYS[key];
		end
		if (t != 8'h00)
			add_result(sc2c_pkg::KIND_CHAR, t);
	endfunction

	task automatic send_key(input key_row_t row);
		key_result_t r;
		int unsigned g;
		in_valid <= 1'b1;
		key_byte <= row.code;
		do
			@(posedge clk);
		while (!in_ready);
		decode_key(row.code);
		if (row.typed) begin
			decoded_n = row.n;
			decoded[0].kind  = row.k0;
			decoded[0].value = row.v0;
			decoded[1].kind  = row.k1;
			decoded[1].value = row.v1;
		end
		for (int i = 0; i < decoded_n; i++) begin
			r = decoded[i];
			r.last = (i == decoded_n - 1);
			char_queue.push_back(r);
		end
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic logic [7:0] pick_modifier();
		case ($urandom_range(0, 3))
			0: return {1'b0, sc2c_pkg::KeyAlt};
			1: return {1'b0, sc2c_pkg::KeyCtrl};
			2: return {1'b0, sc2c_pkg::KeyLShift};
			default: return {1'b0, sc2c_pkg::KeyRShift};
		endcase
	endfunction

	function automatic logic [7:0] pick_lock();
		case ($urandom_range(0, 2))
			0: return {1'b0, sc2c_pkg::KeyScroll};
			1: return {1'b0, sc2c_pkg::KeyNum};
			default: return {1'b0, sc2c_pkg::KeyCaps};
		endcase
	endfunction

	function automatic logic [7:0] random_code();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 8'($urandom_range(0, KEY_COUNT - 1));
		if (r < 57)
			return pick_modifier();
		if (r < 77)
			return pick_modifier() | 8'h80;
		if (r < 83)
			return pick_lock();
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		key_row_t row;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < ROW_COUNT; i++)
			send_key(KEY_ROWS[i]);
		row = '0;
		row.typed = PREDICTED;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == HOLD_AT)
				long_hold_due = 1'b1;
			row.code = random_code();
			send_key(row);
		end
		in_valid <= 1'b0;
		while (char_queue.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (char_queue.size() != 0)
			report_mismatch("results still outstanding at the end");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// The receiver stalls at random; once it holds off long enough for the input to back up.
	initial begin
		int unsigned g;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (long_hold_due) begin
				long_hold_due = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			g = gap_len();
			if (g > 0) begin
				out_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		key_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (char_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected beat: kind %0d value %02h last %0b",
					kind, value, last));
			end else begin
				want = char_queue.pop_front();
				if (kind !== want.kind)
					report_mismatch($sformatf("kind %0d, wanted %0d", kind, want.kind));
				if (value !== want.value)
					report_mismatch($sformatf("value %02h, wanted %02h", value, want.value));
				if (last !== want.last)
					report_mismatch($sformatf("last %0b, wanted %0b", last, want.last));
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
